// ===== src/imu_bias_calibrate_and_scale_assert.svh =====
`ifndef IMU_BIAS_CALIBRATE_AND_SCALE_ASSERT_SVH
`define IMU_BIAS_CALIBRATE_AND_SCALE_ASSERT_SVH
// implication checked in the same cycle
`define IBCS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ibcs assertion failed");
// implication checked in the next cycle
`define IBCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ibcs assertion failed");
`endif

// ===== src/ibcs_pkg.sv =====
package ibcs_pkg;

    typedef struct packed {
        logic signed [15:0] accel_raw_x;
        logic signed [15:0] accel_raw_y;
        logic signed [15:0] accel_raw_z;
        logic signed [15:0] gyro_raw_x;
        logic signed [15:0] gyro_raw_y;
        logic signed [15:0] gyro_raw_z;
        logic signed [15:0] temp_sample;
        logic [31:0]        sample_time;
        logic [1:0]         cal_start;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] accel_out_x;
        logic signed [31:0] accel_out_y;
        logic signed [31:0] accel_out_z;
        logic signed [31:0] gyro_out_x;
        logic signed [31:0] gyro_out_y;
        logic signed [31:0] gyro_out_z;
        logic signed [31:0] temperature;
        logic [31:0]        time_out;
        logic [1:0]         cal_busy;
        logic               cal_done;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] value;
    } t_cfg_item;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} t_state;

    localparam logic [2:0] REG_ACCEL_SCALE  = 3'd0;
    localparam logic [2:0] REG_GYRO_SCALE   = 3'd1;
    localparam logic [2:0] REG_TEMP_DIVISOR = 3'd2;
    localparam logic [2:0] REG_TEMP_OFFSET  = 3'd3;
    localparam logic [2:0] REG_ONE_G_COUNTS = 3'd4;

    localparam logic [30:0] RST_ACCEL_SCALE  = 31'd157;
    localparam logic [30:0] RST_GYRO_SCALE   = 31'd70;
    localparam logic [30:0] RST_TEMP_DIVISOR = 31'd22282240;
    localparam logic [31:0] RST_TEMP_OFFSET  = 32'd2394030;
    localparam logic [14:0] RST_ONE_G_COUNTS = 15'd4096;

    localparam int LANES      = 6;
    localparam int MUL_STEPS  = 17;
    localparam int BDIV_STEPS = 27;
    localparam int TDIV_STEPS = 49;

    localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

endpackage

// ===== src/ibcs_if.sv =====
interface ibcs_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/imu_bias_calibrate_and_scale.sv =====
// IMU sample conversion with bias calibration. One sample in, one Q16.16 result out.
// An accepted sample runs through the bit-serial temperature divider (one quotient
// bit a cycle), which also covers the six bit-serial scale multipliers and the bias
// mean dividers, then through a finish state that waits for the output register to
// be free. The next sample is accepted the cycle after the result has moved to the
// output register, so a new sample is not taken while one is still in flight.
// Configuration writes are taken every cycle.
`include "imu_bias_calibrate_and_scale_assert.svh"
module imu_bias_calibrate_and_scale
    import ibcs_pkg::*;
#(
    parameter int CAL_PASSES = 1000
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ibcs_if.sink  i_in,
    ibcs_if.source o_out,
    ibcs_if.sink  i_cfg
);

    localparam logic [9:0]  PASSES10 = 10'(CAL_PASSES);
    localparam logic [10:0] PASSES11 = 11'(CAL_PASSES);
    localparam logic [5:0]  LAST_CNT = 6'(TDIV_STEPS - 1);

    t_state r_state, n_state;
    logic [5:0] r_cnt;

    logic [30:0] r_accel_scale, r_gyro_scale, r_temp_div;
    logic [31:0] r_temp_off;
    logic [14:0] r_one_g;

    logic [1:0]  r_active;
    logic [9:0]  r_gcnt, r_acnt;
    logic signed [25:0] r_gsum [3];
    logic signed [26:0] r_asum [3];
    logic signed [15:0] r_gbias [3];
    logic signed [15:0] r_abias [3];

    logic [16:0] r_mag [LANES];
    logic [47:0] r_acc [LANES];
    logic        r_neg [LANES];
    logic [30:0] r_scale [LANES];

    logic [26:0] r_bd [LANES];
    logic [9:0]  r_brem [LANES];
    logic [26:0] r_bq [LANES];
    logic        r_bneg [LANES];
    logic        r_gfin, r_afin;

    logic [48:0] r_td;
    logic [30:0] r_trem;
    logic [48:0] r_tq;
    logic        r_tneg, r_tzero;

    logic [31:0] r_time;
    logic [1:0]  r_busy;
    logic        r_done;

    t_out_item   r_out;
    logic        r_ovalid;

    logic in_acc, out_load;
    logic [1:0] act, act_after;
    logic gfin, afin;
    logic [9:0] gcnt_inc, acnt_inc;
    logic signed [25:0] gsum_new [3];
    logic signed [26:0] asum_new [3];
    logic signed [16:0] diff [LANES];
    logic signed [16:0] raw17 [LANES];
    logic signed [17:0] az_adj;
    logic [31:0] lane_res [LANES];
    logic [15:0] bias_res [LANES];
    logic [49:0] t_round;
    logic [31:0] t_q;
    logic signed [32:0] t_sum;
    logic [31:0] t_res;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_load = (r_state == ST_FIN) && (!r_ovalid || o_out.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_acc) n_state = ST_RUN;
            ST_RUN:  if (r_cnt == LAST_CNT) n_state = ST_FIN;
            ST_FIN:  if (out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready  = (r_state == ST_IDLE);
        i_cfg.ready = 1'b1;
        o_out.valid = r_ovalid;
        o_out.data  = r_out;
    end

    always_comb begin
        raw17[0] = 17'(i_in.data.accel_raw_x);
        raw17[1] = 17'(i_in.data.accel_raw_y);
        raw17[2] = 17'(i_in.data.accel_raw_z);
        raw17[3] = 17'(i_in.data.gyro_raw_x);
        raw17[4] = 17'(i_in.data.gyro_raw_y);
        raw17[5] = 17'(i_in.data.gyro_raw_z);
        for (int i = 0; i < 3; i++) begin
            diff[i]     = raw17[i] - 17'(r_abias[i]);
            diff[i + 3] = raw17[i + 3] - 17'(r_gbias[i]);
        end
        act      = r_active | i_in.data.cal_start;
        gcnt_inc = r_gcnt + 10'd1;
        acnt_inc = r_acnt + 10'd1;
        gfin     = act[0] && (gcnt_inc == PASSES10);
        afin     = act[1] && (acnt_inc == PASSES10);
        az_adj   = 18'(raw17[2]) - $signed({3'b000, r_one_g});
        for (int i = 0; i < 3; i++) begin
            gsum_new[i] = r_gsum[i] + 26'(raw17[i + 3]);
        end
        asum_new[0] = r_asum[0] + 27'(raw17[0]);
        asum_new[1] = r_asum[1] + 27'(raw17[1]);
        asum_new[2] = r_asum[2] + 27'(az_adj);
        act_after   = act & ~{afin, gfin};
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            if (!r_neg[i]) begin
                lane_res[i] = (r_acc[i] > 48'(S32_MAX)) ? S32_MAX : r_acc[i][31:0];
            end else begin
                lane_res[i] = (r_acc[i] > 48'(S32_MIN)) ? S32_MIN : -r_acc[i][31:0];
            end
            if (!r_bneg[i]) begin
                bias_res[i] = (r_bq[i] > 27'd32767) ? 16'h7fff : r_bq[i][15:0];
            end else begin
                bias_res[i] = (r_bq[i] > 27'd32768) ? 16'h8000 : -r_bq[i][15:0];
            end
        end
        t_round = ({1'b0, r_tq} + 50'd1) >> 1;
        if (r_temp_div == 31'd0) begin
            t_q = r_tneg ? S32_MIN : (r_tzero ? 32'd0 : S32_MAX);
        end else if (!r_tneg) begin
            t_q = (t_round > 50'(S32_MAX)) ? S32_MAX : t_round[31:0];
        end else begin
            t_q = (t_round > 50'(S32_MIN)) ? S32_MIN : -t_round[31:0];
        end
        t_sum = $signed({t_q[31], t_q}) + $signed({r_temp_off[31], r_temp_off});
        if (t_sum > $signed({1'b0, S32_MAX})) begin
            t_res = S32_MAX;
        end else if (t_sum < $signed({1'b1, S32_MIN})) begin
            t_res = S32_MIN;
        end else begin
            t_res = t_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_cnt         <= 6'd0;
            r_ovalid      <= 1'b0;
            r_accel_scale <= RST_ACCEL_SCALE;
            r_gyro_scale  <= RST_GYRO_SCALE;
            r_temp_div    <= RST_TEMP_DIVISOR;
            r_temp_off    <= RST_TEMP_OFFSET;
            r_one_g       <= RST_ONE_G_COUNTS;
            r_active      <= 2'b00;
            r_gcnt        <= 10'd0;
            r_acnt        <= 10'd0;
            r_gfin        <= 1'b0;
            r_afin        <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_gsum[i]  <= '0;
                r_asum[i]  <= '0;
                r_gbias[i] <= '0;
                r_abias[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg.valid) begin
                case (i_cfg.data.index)
                    REG_ACCEL_SCALE:  r_accel_scale <= i_cfg.data.value[30:0];
                    REG_GYRO_SCALE:   r_gyro_scale  <= i_cfg.data.value[30:0];
                    REG_TEMP_DIVISOR: r_temp_div    <= i_cfg.data.value[30:0];
                    REG_TEMP_OFFSET:  r_temp_off    <= i_cfg.data.value;
                    REG_ONE_G_COUNTS: r_one_g       <= i_cfg.data.value[14:0];
                    default: ;
                endcase
            end

            if (in_acc) begin
                r_cnt    <= 6'd0;
                r_active <= act_after;
                r_busy   <= act_after;
                r_done   <= (act != 2'b00) && (act_after == 2'b00);
                r_time   <= i_in.data.sample_time;
                r_gfin   <= gfin;
                r_afin   <= afin;
                for (int i = 0; i < LANES; i++) begin
                    r_mag[i]   <= diff[i][16] ? -diff[i] : diff[i];
                    r_acc[i]   <= '0;
                    r_scale[i] <= (i < 3) ? r_accel_scale : r_gyro_scale;
                    r_brem[i]  <= '0;
                    r_bq[i]    <= '0;
                end
                r_neg[0] <= !diff[0][16] && (diff[0] != 17'sd0);
                r_neg[1] <= diff[1][16];
                r_neg[2] <= diff[2][16];
                r_neg[3] <= diff[3][16];
                r_neg[4] <= !diff[4][16] && (diff[4] != 17'sd0);
                r_neg[5] <= !diff[5][16] && (diff[5] != 17'sd0);
                if (act[0]) begin
                    r_gcnt <= gfin ? 10'd0 : gcnt_inc;
                    for (int i = 0; i < 3; i++) begin
                        r_gsum[i]     <= gfin ? 26'sd0 : gsum_new[i];
                        r_bd[i + 3]   <= 27'(gsum_new[i][25] ? -gsum_new[i] : gsum_new[i]);
                        r_bneg[i + 3] <= gsum_new[i][25];
                    end
                end
                if (act[1]) begin
                    r_acnt <= afin ? 10'd0 : acnt_inc;
                    for (int i = 0; i < 3; i++) begin
                        r_asum[i] <= afin ? 27'sd0 : asum_new[i];
                        r_bd[i]   <= asum_new[i][26] ? -asum_new[i] : asum_new[i];
                        r_bneg[i] <= asum_new[i][26];
                    end
                end
                r_td    <= {(i_in.data.temp_sample[15] ? -i_in.data.temp_sample
                                                       : i_in.data.temp_sample), 33'd0};
                r_trem  <= '0;
                r_tq    <= '0;
                r_tneg  <= i_in.data.temp_sample[15];
                r_tzero <= (i_in.data.temp_sample == 16'sd0);
            end

            if (r_state == ST_RUN) begin
                r_cnt <= r_cnt + 6'd1;
                for (int i = 0; i < LANES; i++) begin
                    if (r_cnt < 6'(MUL_STEPS)) begin
                        r_acc[i] <= {r_acc[i][46:0], 1'b0}
                                    + (r_mag[i][16] ? 48'(r_scale[i]) : 48'd0);
                        r_mag[i] <= {r_mag[i][15:0], 1'b0};
                    end
                    if (r_cnt < 6'(BDIV_STEPS)) begin
                        if ({r_brem[i], r_bd[i][26]} >= PASSES11) begin
                            r_brem[i] <= 10'({r_brem[i], r_bd[i][26]} - PASSES11);
                            r_bq[i]   <= {r_bq[i][25:0], 1'b1};
                        end else begin
                            r_brem[i] <= {r_brem[i][8:0], r_bd[i][26]};
                            r_bq[i]   <= {r_bq[i][25:0], 1'b0};
                        end
                        r_bd[i] <= {r_bd[i][25:0], 1'b0};
                    end
                end
                if ({r_trem, r_td[48]} >= {1'b0, r_temp_div}) begin
                    r_trem <= 31'({r_trem, r_td[48]} - {1'b0, r_temp_div});
                    r_tq   <= {r_tq[47:0], 1'b1};
                end else begin
                    r_trem <= {r_trem[29:0], r_td[48]};
                    r_tq   <= {r_tq[47:0], 1'b0};
                end
                r_td <= {r_td[47:0], 1'b0};
            end

            if (out_load) begin
                r_ovalid          <= 1'b1;
                r_out.accel_out_x <= lane_res[0];
                r_out.accel_out_y <= lane_res[1];
                r_out.accel_out_z <= lane_res[2];
                r_out.gyro_out_x  <= lane_res[3];
                r_out.gyro_out_y  <= lane_res[4];
                r_out.gyro_out_z  <= lane_res[5];
                r_out.temperature <= t_res;
                r_out.time_out    <= r_time;
                r_out.cal_busy    <= r_busy;
                r_out.cal_done    <= r_done;
                for (int i = 0; i < 3; i++) begin
                    if (r_afin) r_abias[i] <= bias_res[i];
                    if (r_gfin) r_gbias[i] <= bias_res[i + 3];
                end
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    `IBCS_ASSERT_NEXT(a_accept_runs, in_acc, r_state == ST_RUN)
    `IBCS_ASSERT_NEXT(a_run_ends, (r_state == ST_RUN) && (r_cnt == LAST_CNT), r_state == ST_FIN)
    `IBCS_ASSERT_NOW(a_done_idle, r_ovalid && r_out.cal_done, r_out.cal_busy == 2'b00)
    `IBCS_ASSERT_NEXT(a_load_valid, out_load, r_ovalid && (r_state == ST_IDLE))

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
module tb;
    import ibcs_pkg::*;

    logic i_clk;
    logic i_rst_n;
    bit   calm;
    int   errors;

    ibcs_if #(.T(t_in_item))  in_if ();
    ibcs_if #(.T(t_out_item)) out_if ();
    ibcs_if #(.T(t_cfg_item)) cfg_if ();

    imu_bias_calibrate_and_scale DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source),
        .i_cfg   (cfg_if.sink)
    );

    localparam int  PASSES = 1000;
    localparam int  SETTLE = 60;
    localparam real CUT_NS = 30_000_000.0;

    // predictor copy of registers and calibration state
    logic [30:0] m_accel_scale, m_gyro_scale, m_temp_div;
    logic [31:0] m_temp_off;
    logic [14:0] m_one_g;
    logic [1:0]  m_active;
    int          m_gyro_cnt, m_accel_cnt;
    longint      m_gyro_sum[3], m_accel_sum[3], m_gyro_bias[3], m_accel_bias[3];

    t_out_item pending[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(CUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return S32_MAX;
        if (v < -64'sd2147483648) return S32_MIN;
        return v[31:0];
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic logic [31:0] temp_degc(longint t);
        longint q;
        longint unsigned mag, r;
        if (m_temp_div == 0) begin
            q = t > 0 ? 64'sd2147483647 : (t < 0 ? -64'sd2147483648 : 0);
        end else begin
            mag = t < 0 ? -t : t;
            r = (((mag << 33) / longint'(m_temp_div)) + 1) >> 1;
            q = t < 0 ? -longint'(r) : longint'(r);
            q = longint'($signed(sat32(q)));
        end
        return sat32(q + longint'($signed(m_temp_off)));
    endfunction

    function automatic t_out_item convert_sample(t_in_item s);
        t_out_item o;
        longint a[3], g[3];
        logic [1:0] was;
        a[0] = longint'(s.accel_raw_x); a[1] = longint'(s.accel_raw_y);
        a[2] = longint'(s.accel_raw_z);
        g[0] = longint'(s.gyro_raw_x);  g[1] = longint'(s.gyro_raw_y);
        g[2] = longint'(s.gyro_raw_z);
        o.accel_out_x = sat32(-(a[0] - m_accel_bias[0]) * longint'(m_accel_scale));
        o.accel_out_y = sat32((a[1] - m_accel_bias[1]) * longint'(m_accel_scale));
        o.accel_out_z = sat32((a[2] - m_accel_bias[2]) * longint'(m_accel_scale));
        o.gyro_out_x  = sat32((g[0] - m_gyro_bias[0]) * longint'(m_gyro_scale));
        o.gyro_out_y  = sat32(-(g[1] - m_gyro_bias[1]) * longint'(m_gyro_scale));
        o.gyro_out_z  = sat32(-(g[2] - m_gyro_bias[2]) * longint'(m_gyro_scale));
        o.temperature = temp_degc(longint'(s.temp_sample));
        o.time_out    = s.sample_time;
        m_active = m_active | s.cal_start;
        was = m_active;
        if (m_active[0]) begin
            for (int i = 0; i < 3; i++) m_gyro_sum[i] += g[i];
            m_gyro_cnt = (m_gyro_cnt + 1) % 1024;
            if (m_gyro_cnt >= PASSES && m_gyro_cnt != 0) begin
                for (int i = 0; i < 3; i++) begin
                    m_gyro_bias[i] = clamp16(m_gyro_sum[i] / longint'(m_gyro_cnt));
                    m_gyro_sum[i] = 0;
                end
                m_gyro_cnt = 0;
                m_active[0] = 1'b0;
            end
        end
        if (m_active[1]) begin
            m_accel_sum[0] += a[0];
            m_accel_sum[1] += a[1];
            m_accel_sum[2] += a[2] - longint'(m_one_g);
            m_accel_cnt = (m_accel_cnt + 1) % 1024;
            if (m_accel_cnt >= PASSES && m_accel_cnt != 0) begin
                for (int i = 0; i < 3; i++) begin
                    m_accel_bias[i] = clamp16(m_accel_sum[i] / longint'(m_accel_cnt));
                    m_accel_sum[i] = 0;
                end
                m_accel_cnt = 0;
                m_active[1] = 1'b0;
            end
        end
        o.cal_busy = m_active;
        o.cal_done = (was != 0 && m_active == 0);
        return o;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            errors++;
            $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        end
    endtask

    // result checker
    initial begin
        t_out_item w, r;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                r = out_if.data;
                if (pending.size() == 0) begin
                    errors++;
                    $display("unexpected transaction at %0t", $realtime);
                end else begin
                    w = pending.pop_front();
                    report("accel_x", r.accel_out_x, w.accel_out_x);
                    report("accel_y", r.accel_out_y, w.accel_out_y);
                    report("accel_z", r.accel_out_z, w.accel_out_z);
                    report("gyro_x", r.gyro_out_x, w.gyro_out_x);
                    report("gyro_y", r.gyro_out_y, w.gyro_out_y);
                    report("gyro_z", r.gyro_out_z, w.gyro_out_z);
                    report("temperature", r.temperature, w.temperature);
                    report("time", r.time_out, w.time_out);
                    report("cal_busy", r.cal_busy, w.cal_busy);
                    report("cal_done", r.cal_done, w.cal_done);
                end
            end
        end
    end

    // output back-pressure
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 4) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
        end
    end

    task automatic send_sample(t_in_item s);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= s;
        do @(posedge i_clk); while (!in_if.ready);
        pending.push_back(convert_sample(s));
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{index: idx, value: val};
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            REG_ACCEL_SCALE:  m_accel_scale = val[30:0];
            REG_GYRO_SCALE:   m_gyro_scale  = val[30:0];
            REG_TEMP_DIVISOR: m_temp_div    = val[30:0];
            REG_TEMP_OFFSET:  m_temp_off    = val;
            REG_ONE_G_COUNTS: m_one_g       = val[14:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [31:0] as, logic [31:0] gs, logic [31:0] td,
                              logic [31:0] tof, logic [31:0] og);
        drain();
        write_reg(REG_ACCEL_SCALE, as);
        write_reg(REG_GYRO_SCALE, gs);
        write_reg(REG_TEMP_DIVISOR, td);
        write_reg(REG_TEMP_OFFSET, tof);
        write_reg(REG_ONE_G_COUNTS, og);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_raw();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item rand_sample(logic [1:0] start);
        t_in_item s;
        s.accel_raw_x = rand_raw(); s.accel_raw_y = rand_raw(); s.accel_raw_z = rand_raw();
        s.gyro_raw_x  = rand_raw(); s.gyro_raw_y  = rand_raw(); s.gyro_raw_z  = rand_raw();
        s.temp_sample = rand_raw();
        s.sample_time = $urandom;
        s.cal_start   = start;
        return s;
    endfunction

    function automatic t_in_item flat_sample(logic [15:0] v, logic [31:0] ts,
                                             logic [1:0] start);
        return '{v, v, v, v, v, v, v, ts, start};
    endfunction

    task automatic test_extremes();
        send_sample(flat_sample(16'h7fff, 32'hffff_ffff, 2'b00));
        send_sample(flat_sample(16'h8000, 32'h0000_0000, 2'b00));
        send_sample(flat_sample(16'h0000, 32'h5555_aaaa, 2'b00));
        send_sample(flat_sample(16'hffff, 32'haaaa_5555, 2'b00));
        set_config(32'h7fff_ffff, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'h7fff);
        send_sample(flat_sample(16'h7fff, 32'd1, 2'b00));
        send_sample(flat_sample(16'h8000, 32'd2, 2'b00));
        send_sample(flat_sample(16'h0001, 32'd3, 2'b00));
        set_config(32'd0, 32'd0, 32'h7fff_ffff, 32'h8000_0000, 32'd0);
        send_sample(flat_sample(16'h7fff, 32'd4, 2'b00));
        send_sample(flat_sample(16'h8000, 32'd5, 2'b00));
        set_config(32'h0001_0000, 32'h0000_8000, 32'h0000_0003, 32'hffff_0000, 32'd4096);
        for (int i = 0; i < 8; i++) send_sample(rand_sample(2'b00));
    endtask

    // gyro starts first, accel joins later; done flags only when both have ended
    task automatic test_calibration();
        t_in_item s;
        set_config(32'd157, 32'd70, 32'd22282240, 32'd2394030, 32'h7fff);
        for (int i = 0; i < 1300; i++) begin
            s = rand_sample(2'b00);
            if (i == 0) s.cal_start = 2'b01;
            if (i == 300) s.cal_start = 2'b10;
            if (i == 500 || i == 900) s.cal_start = 2'b11;
            if ($urandom_range(0, 9) != 0) s.accel_raw_z = 16'h8000;
            s.gyro_raw_x = 16'($signed($urandom_range(0, 200)) - 50);
            send_sample(s);
            if (i == 650) drain();
        end
    endtask

    task automatic test_random();
        set_config($urandom_range(0, 2000), $urandom_range(0, 2000),
                   $urandom_range(1, 32'h7fff_ffff), $urandom, $urandom_range(0, 32767));
        for (int i = 0; i < 400; i++) begin
            if (i == 250) calm = 1'b1;
            send_sample(rand_sample($urandom_range(0, 29) == 0 ? 2'($urandom) : 2'b00));
        end
    endtask

    initial begin
        calm = 1'b0;
        errors = 0;
        i_rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.data <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data <= '0;
        m_accel_scale = RST_ACCEL_SCALE;
        m_gyro_scale = RST_GYRO_SCALE;
        m_temp_div = RST_TEMP_DIVISOR;
        m_temp_off = RST_TEMP_OFFSET;
        m_one_g = RST_ONE_G_COUNTS;
        m_active = '0;
        m_gyro_cnt = 0;
        m_accel_cnt = 0;
        for (int i = 0; i < 3; i++) begin
            m_gyro_sum[i] = 0; m_accel_sum[i] = 0;
            m_gyro_bias[i] = 0; m_accel_bias[i] = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_calibration();
        test_random();
        drain();
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/ibcs_pkg.sv
src/ibcs_if.sv
src/imu_bias_calibrate_and_scale.sv
sim/tb.sv
